/* hdl/bal_pkg.sv */
// Shared types, constants and a helper function for the buddy allocator.
// Depends on nothing; used by buddy_allocator.
package bal_pkg;

    // Default number of block orders; the pool holds 2^(ORDERS-1) units.
    localparam int ORDERS_DEF = 16;

    // Width of an order value; it covers every order up to the largest legal ORDERS.
    localparam int ORD_W = 5;

    // Operation codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // One request transaction.
    typedef struct packed {
        logic        func;
        logic [15:0] req_size;
        logic [14:0] block_offset;
    } req_t;

    // One result transaction.
    typedef struct packed {
        logic        ok;
        logic [14:0] result_offset;
    } rsp_t;

    // Smallest order whose block size covers the request; a size of zero acts as one.
    function automatic logic [ORD_W-1:0] order_of(input logic [15:0] size);
        logic [ORD_W-1:0] cnt;
        cnt = '0;
        for (int k = 0; k < 17; k++) begin
            if ((17'(1) << k) < 17'(size)) begin
                cnt = cnt + ORD_W'(1);
            end
        end
        return cnt;
    endfunction

endpackage

/* hdl/bal_link_mem.sv */
// Link memory of the buddy allocator: one next-pointer word per block offset.
// Single write port, single read port with registered read data. No package use.
module bal_link_mem #(
    parameter int AW = 15,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW)-1];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/buddy_allocator.sv */
// Binary buddy allocator with one LIFO free list per order and a link memory.
// Allocate: pops the lowest nonempty order at or above the one asked for, then splits down to it.
// Free: walks each order's list for the buddy, merging one order up per match, then pushes the
// final block. A request of too large an order is refused with ok low straight from idle.
// One request at a time. After reset the block initializes the whole-pool link in S_INIT,
// busy high. The result shows for one cycle with done high; no stall.
module buddy_allocator #(
    parameter int ORDERS = bal_pkg::ORDERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bal_pkg::req_t req,
    output logic          done,
    output bal_pkg::rsp_t rsp
);

    localparam int OW   = ORDERS - 1;
    localparam int HW   = (ORDERS > 2) ? $clog2(ORDERS) : 1;
    localparam int SW   = OW + 1;
    localparam int LW   = OW + 1;
    localparam int OD_W = bal_pkg::ORD_W;
    localparam logic [OD_W-1:0] ORD_LIM = OD_W'(ORDERS);
    localparam logic [OD_W-1:0] ORD_TOP = OD_W'(ORDERS - 1);
    localparam logic [SW-1:0]   POOL    = SW'(1) << OW;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_POP_RD   = 4'd2;
    localparam logic [3:0] S_POP_WB   = 4'd3;
    localparam logic [3:0] S_SPLIT    = 4'd4;
    localparam logic [3:0] S_FREE_CHK = 4'd5;
    localparam logic [3:0] S_WALK_RD  = 4'd6;
    localparam logic [3:0] S_WALK_WB  = 4'd7;
    localparam logic [3:0] S_PUSH     = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [OD_W-1:0] ord_reg, ord_next;
    logic [OD_W-1:0] tgt_reg, tgt_next;
    logic [OW-1:0]   off_reg, off_next;
    logic [OW-1:0]   cur_reg, cur_next;
    logic [OW-1:0]   prev_reg, prev_next;
    logic            have_reg, have_next;
    logic            at_head_reg, at_head_next;
    logic            match_reg, match_next;
    logic [SW-1:0]   steps_reg, steps_next;
    logic            done_reg, done_next;
    logic            ok_reg, ok_next;
    logic [OW-1:0]   res_reg, res_next;
    logic [OW-1:0]   head_reg [ORDERS];
    logic [ORDERS-1:0] hval_reg;

    // Head update port.
    logic          hw_en;
    logic [HW-1:0] hw_idx;
    logic [OW-1:0] hw_off;
    logic          hw_val;

    // Link memory port.
    logic          mem_we;
    logic [OW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic [OW-1:0] mem_raddr;
    logic [LW-1:0] mem_rdata;

    logic [HW-1:0]   hidx;
    logic [OD_W-1:0] req_ord;
    logic [31:0]     in_ext;
    logic [OW-1:0]   in_off;
    logic [OW-1:0]   bit_k;
    logic [OW-1:0]   buddy;
    logic [OD_W-1:0] found_ord;
    logic            found;
    logic [31:0]     res_ext;

    bal_link_mem #(
        .AW(OW),
        .DW(LW)
    ) u_link (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Request decode and buddy arithmetic.
    assign hidx    = ord_reg[HW-1:0];
    assign req_ord = bal_pkg::order_of(req.req_size);
    assign in_ext  = 32'(req.block_offset);
    assign in_off  = in_ext[OW-1:0];
    assign bit_k   = OW'(1) << ord_reg;
    assign buddy   = off_reg ^ bit_k;

    // Lowest nonempty order at or above the requested one.
    always_comb
    begin
        found     = 1'b0;
        found_ord = '0;
        for (int k = ORDERS - 1; k >= 0; k--)
        begin
            if (hval_reg[k] && (OD_W'(k) >= req_ord))
            begin
                found     = 1'b1;
                found_ord = OD_W'(k);
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        ord_next     = ord_reg;
        tgt_next     = tgt_reg;
        off_next     = off_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        have_next    = have_reg;
        at_head_next = at_head_reg;
        match_next   = match_reg;
        steps_next   = steps_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        res_next     = res_reg;
        hw_en        = 1'b0;
        hw_idx       = hidx;
        hw_off       = '0;
        hw_val       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = off_reg;

        unique case (state_reg)
            S_INIT:
            begin
                // The whole-pool block starts as the end of its list.
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_ord >= ORD_LIM)
                    begin
                        done_next = 1'b1;
                        ok_next   = 1'b0;
                        res_next  = '0;
                    end
                    else if (req.func == bal_pkg::FUNC_ALLOC)
                    begin
                        if (!found)
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b0;
                            res_next  = '0;
                        end
                        else
                        begin
                            ord_next   = found_ord;
                            tgt_next   = req_ord;
                            off_next   = head_reg[found_ord[HW-1:0]];
                            state_next = S_POP_RD;
                        end
                    end
                    else
                    begin
                        ord_next   = req_ord;
                        off_next   = in_off;
                        state_next = S_FREE_CHK;
                    end
                end
            end
            S_POP_RD:
            begin
                mem_raddr  = off_reg;
                state_next = S_POP_WB;
            end
            S_POP_WB:
            begin
                // Unlink the popped block from its list.
                hw_en  = 1'b1;
                hw_off = mem_rdata[OW-1:0];
                hw_val = mem_rdata[OW];
                if (ord_reg == tgt_reg)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    res_next   = off_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    ord_next   = ord_reg - OD_W'(1);
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                // Push the upper half onto the list of the current order.
                mem_we    = 1'b1;
                mem_waddr = buddy;
                mem_wdata = hval_reg[hidx] ? {1'b1, head_reg[hidx]} : '0;
                hw_en     = 1'b1;
                hw_off    = buddy;
                hw_val    = 1'b1;
                if (ord_reg == tgt_reg)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    res_next   = off_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    ord_next = ord_reg - OD_W'(1);
                end
            end
            S_FREE_CHK:
            begin
                if (ord_reg == ORD_TOP)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cur_next     = head_reg[hidx];
                    have_next    = hval_reg[hidx];
                    at_head_next = 1'b1;
                    steps_next   = '0;
                    state_next   = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                if (!have_reg || (steps_reg == POOL))
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    mem_raddr  = cur_reg;
                    match_next = (cur_reg == buddy);
                    state_next = S_WALK_WB;
                end
            end
            S_WALK_WB:
            begin
                if (match_reg)
                begin
                    // Unlink the buddy and merge one order up.
                    if (at_head_reg)
                    begin
                        hw_en  = 1'b1;
                        hw_off = mem_rdata[OW-1:0];
                        hw_val = mem_rdata[OW];
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = prev_reg;
                        mem_wdata = mem_rdata;
                    end
                    if (buddy < off_reg)
                    begin
                        off_next = buddy;
                    end
                    ord_next   = ord_reg + OD_W'(1);
                    state_next = S_FREE_CHK;
                end
                else
                begin
                    prev_next    = cur_reg;
                    at_head_next = 1'b0;
                    have_next    = mem_rdata[OW];
                    cur_next     = mem_rdata[OW-1:0];
                    steps_next   = steps_reg + SW'(1);
                    state_next   = S_WALK_RD;
                end
            end
            S_PUSH:
            begin
                mem_we     = 1'b1;
                mem_waddr  = off_reg;
                mem_wdata  = hval_reg[hidx] ? {1'b1, head_reg[hidx]} : '0;
                hw_en      = 1'b1;
                hw_off     = off_reg;
                hw_val     = 1'b1;
                done_next  = 1'b1;
                ok_next    = 1'b1;
                res_next   = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
            hval_reg  <= {1'b1, {(ORDERS-1){1'b0}}};
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (hw_en)
            begin
                hval_reg[hw_idx] <= hw_val;
            end
        end
    end

    // List heads; the top order holds offset zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[ORDERS-1] <= '0;
        end
        else if (hw_en)
        begin
            head_reg[hw_idx] <= hw_off;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ord_reg     <= ord_next;
        tgt_reg     <= tgt_next;
        off_reg     <= off_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        have_reg    <= have_next;
        at_head_reg <= at_head_next;
        match_reg   <= match_next;
        steps_reg   <= steps_next;
        ok_reg      <= ok_next;
        res_reg     <= res_next;
    end

    // Outputs.
    assign res_ext           = 32'(res_reg);
    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign rsp.ok            = ok_reg;
    assign rsp.result_offset = res_ext[14:0];

endmodule
